/* src/assert_macros.svh */
// Assertion macros used by the top level of the slot table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked property, switched off while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, evaluated at every rising clock edge.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* src/ffks_pkg.sv */
// Package with the widths, request codes and defaults of the slot table.
`timescale 1ns / 1ps
`default_nettype none
package ffks_pkg;
   // Default table geometry.
   localparam int SLOTS_DEF    = 64;
   localparam int KEY_BITS_DEF = 32;

   // Port field widths.
   localparam int REQ_TYPE_W = 2;
   localparam int ITEM_KEY_W = 32;
   localparam int LIMIT_W    = 7;
   localparam int SEL_W      = 6;
   localparam int USED_W     = 6;
   localparam int TOTAL_W    = 7;

   // Largest value that the match total field can carry.
   localparam int MATCH_MAX = 127;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] OP_ADD    = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] OP_COUNT  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] OP_READ   = 2'd3;
endpackage
`default_nettype wire

/* src/ffks_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ffks_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* src/first_fit_keyed_slot_table_top.sv */
// Top level of the first-fit keyed slot table.
//
//   channel   handshake              payload
//   request   start high, busy low   req_type, req_item_key, req_remove_limit,
//                                    req_slot_select
//   response  rsp_valid (one cycle)  rsp_status, rsp_slot_used, rsp_match_total,
//                                    rsp_entry_present, rsp_entry_key
//
// Add, count and remove sweep the slot memory once, one entry read per cycle,
// and the response strobe follows the last entry of the sweep. A read-slot item
// reads only the selected entry. The single memory read port sets the sweep's pace.
// The block returns to idle in the cycle after the strobe and only then accepts
// the next item. After reset a clearing pass writes every entry empty, one per
// cycle, and busy stays high until it ends. The response cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module first_fit_keyed_slot_table_top
   import ffks_pkg::*;
#(
   parameter int SLOTS    = SLOTS_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [REQ_TYPE_W-1:0] req_type,
   input  wire logic [ITEM_KEY_W-1:0] req_item_key,
   input  wire logic [LIMIT_W-1:0]    req_remove_limit,
   input  wire logic [SEL_W-1:0]      req_slot_select,
   output logic                       rsp_valid,
   output logic                       rsp_status,
   output logic [USED_W-1:0]          rsp_slot_used,
   output logic [TOTAL_W-1:0]         rsp_match_total,
   output logic                       rsp_entry_present,
   output logic [ITEM_KEY_W-1:0]      rsp_entry_key
);
   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
   localparam int MW = KEY_BITS + 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_RESP  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [IW-1:0]         issue_idx_ff, issue_idx_in;
   logic                  issuing_ff, issuing_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  rd_last_ff, rd_last_in;
   logic [IW-1:0]         rd_idx_ff, rd_idx_in;
   logic [REQ_TYPE_W-1:0] op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic                  sel_ok_ff, sel_ok_in;
   logic                  found_ff, found_in;
   logic [IW-1:0]         used_ff, used_in;
   logic [CW-1:0]         total_ff, total_in;
   logic                  present_ff, present_in;
   logic [KEY_BITS-1:0]   rkey_ff, rkey_in;

   logic                  mem_we, mem_re;
   logic [IW-1:0]         mem_waddr;
   logic [MW-1:0]         mem_wdata, mem_rdata;
   logic                  ent_valid, ent_match;
   logic [KEY_BITS-1:0]   ent_key;

   logic [KEY_BITS+ITEM_KEY_W-1:0] req_key_ext, out_key_ext;
   logic [IW+SEL_W-1:0]            sel_ext;
   logic [IW+USED_W-1:0]           used_ext;
   logic [LW-1:0]                  total_ext;
   logic [KEY_BITS-1:0]            req_key;
   logic [IW-1:0]                  sel_addr;
   logic                           sel_in_range;

   // Fit the port fields to the table's key and index widths.
   assign req_key_ext  = {{KEY_BITS{1'b0}}, req_item_key};
   assign req_key      = req_key_ext[KEY_BITS-1:0];
   assign sel_ext      = {{IW{1'b0}}, req_slot_select};
   assign sel_addr     = sel_ext[IW-1:0];
   assign sel_in_range = int'(req_slot_select) < SLOTS;

   // Fields of the entry that the memory returned.
   assign ent_valid = mem_rdata[KEY_BITS];
   assign ent_key   = mem_rdata[KEY_BITS-1:0];
   assign ent_match = ent_valid && (ent_key == key_ff);

   ffks_ram #(
      .WIDTH(MW),
      .DEPTH(SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(issue_idx_ff),
      .rd_data(mem_rdata)
   );

   // Sequencer: clearing pass, idle, memory sweep and response cycle.
   always_comb begin
      state_in     = state_ff;
      issue_idx_in = issue_idx_ff;
      issuing_in   = issuing_ff;
      rd_vld_in    = 1'b0;
      rd_last_in   = 1'b0;
      rd_idx_in    = issue_idx_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      limit_in     = limit_ff;
      sel_ok_in    = sel_ok_ff;
      found_in     = found_ff;
      used_in      = used_ff;
      total_in     = total_ff;
      present_in   = present_ff;
      rkey_in      = rkey_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = rd_idx_ff;
      mem_wdata    = {1'b0, ent_key};
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we       = 1'b1;
            mem_waddr    = issue_idx_ff;
            mem_wdata    = '0;
            issue_idx_in = issue_idx_ff + 1'b1;
            if (issue_idx_ff == LAST_IDX) begin
               issue_idx_in = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in        = req_type;
               key_in       = req_key;
               limit_in     = req_remove_limit;
               sel_ok_in    = sel_in_range;
               found_in     = 1'b0;
               used_in      = '0;
               total_in     = '0;
               present_in   = 1'b0;
               rkey_in      = '0;
               issuing_in   = 1'b1;
               issue_idx_in = (req_type == OP_READ) ? sel_addr : '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue one read per cycle until the last entry of the sweep.
            if (issuing_ff) begin
               mem_re     = 1'b1;
               rd_vld_in  = 1'b1;
               rd_last_in = (op_ff == OP_READ) || (issue_idx_ff == LAST_IDX);
               if (rd_last_in) begin
                  issuing_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + 1'b1;
               end
            end
            // Act on the entry read in the previous cycle.
            if (rd_vld_ff) begin
               unique case (op_ff)
                  OP_ADD: begin
                     if (!found_ff && !ent_valid) begin
                        mem_we    = 1'b1;
                        mem_wdata = {1'b1, key_ff};
                        found_in  = 1'b1;
                        used_in   = rd_idx_ff;
                     end
                  end
                  OP_COUNT: begin
                     if (ent_match) begin
                        total_in = CW'(total_ff + 1'b1);
                     end
                  end
                  OP_REMOVE: begin
                     if (ent_match && (LW'(total_ff) < LW'(limit_ff))) begin
                        mem_we   = 1'b1;
                        total_in = CW'(total_ff + 1'b1);
                     end
                  end
                  OP_READ: begin
                     present_in = sel_ok_ff && ent_valid;
                     rkey_in    = (sel_ok_ff && ent_valid) ? ent_key : '0;
                  end
               endcase
               if (rd_last_ff) begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         issue_idx_ff <= '0;
         issuing_ff   <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_idx_ff <= issue_idx_in;
         issuing_ff   <= issuing_in;
         rd_vld_ff    <= rd_vld_in;
         rd_last_ff   <= rd_last_in;
      end
   end

   // Request fields and running results.
   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      op_ff      <= op_in;
      key_ff     <= key_in;
      limit_ff   <= limit_in;
      sel_ok_ff  <= sel_ok_in;
      found_ff   <= found_in;
      used_ff    <= used_in;
      total_ff   <= total_in;
      present_ff <= present_in;
      rkey_ff    <= rkey_in;
   end

   // Response fields, valid while the strobe is high.
   assign out_key_ext = {{ITEM_KEY_W{1'b0}}, rkey_ff};
   assign used_ext    = {{USED_W{1'b0}}, used_ff};
   assign total_ext   = LW'(total_ff);

   assign busy              = state_ff != ST_IDLE;
   assign rsp_valid         = state_ff == ST_RESP;
   assign rsp_status        = (op_ff == OP_ADD) && !found_ff;
   assign rsp_slot_used     = used_ext[USED_W-1:0];
   assign rsp_match_total   = (total_ext > LW'(MATCH_MAX)) ? TOTAL_W'(MATCH_MAX)
                                                           : total_ext[TOTAL_W-1:0];
   assign rsp_entry_present = present_ff;
   assign rsp_entry_key     = out_key_ext[ITEM_KEY_W-1:0];

   // The response strobe lasts one cycle and is followed by an idle cycle.
   `ASSERT_RST(a_rsp_one_cycle, clock, reset, rsp_valid |=> !rsp_valid && !busy, "response strobe held")
   // An accepted item keeps the block busy in the next cycle.
   `ASSERT_RST(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accepted item not started")
   // During a sweep the memory is written only for an entry just read.
   `ASSERT_RST(a_write_after_read, clock, reset, (mem_we && state_ff == ST_SCAN) |-> rd_vld_ff, "write without read data")
   // A refused add reports no slot.
   `ASSERT_RST(a_full_no_slot, clock, reset, (rsp_valid && rsp_status) |-> (rsp_slot_used == '0), "full add reported a slot")
   // The write port never targets the entry being read in the same sweep cycle.
   `ASSERT_RST(a_no_rw_overlap, clock, reset, (mem_we && mem_re) |-> (mem_waddr != issue_idx_ff), "read and write collide")
endmodule
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the first-fit keyed slot table.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import ffks_pkg::*;

   localparam int TABLE_SLOTS = SLOTS_DEF;
   localparam int POOL_KEYS   = 6;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_WAIT  = 80;
   localparam int RANDOM_ITEMS = 1300;

   // Reply fields as the block presents them.
   typedef struct packed {
      logic                  status;
      logic [USED_W-1:0]     slot_used;
      logic [TOTAL_W-1:0]    match_total;
      logic                  entry_present;
      logic [ITEM_KEY_W-1:0] entry_key;
   } slot_reply_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [ITEM_KEY_W-1:0] req_item_key;
   logic [LIMIT_W-1:0]    req_remove_limit;
   logic [SEL_W-1:0]      req_slot_select;
   logic                  rsp_valid;
   logic                  rsp_status;
   logic [USED_W-1:0]     rsp_slot_used;
   logic [TOTAL_W-1:0]    rsp_match_total;
   logic                  rsp_entry_present;
   logic [ITEM_KEY_W-1:0] rsp_entry_key;

   // Shadow copy of the table contents.
   bit                    occupied [TABLE_SLOTS];
   logic [ITEM_KEY_W-1:0] stored_key [TABLE_SLOTS];

   slot_reply_type        pending_replies [$];
   logic [ITEM_KEY_W-1:0] key_pool [POOL_KEYS];
   int unsigned           error_count = 0;
   int unsigned           cycle_count = 0;
   bit                    no_idle_stretch = 1'b0;

   first_fit_keyed_slot_table_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_item_key      (req_item_key),
      .req_remove_limit  (req_remove_limit),
      .req_slot_select   (req_slot_select),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_slot_used     (rsp_slot_used),
      .rsp_match_total   (rsp_match_total),
      .rsp_entry_present (rsp_entry_present),
      .rsp_entry_key     (rsp_entry_key)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Apply one request to the shadow table and return the reply it must give.
   function automatic slot_reply_type apply_table_request(logic [REQ_TYPE_W-1:0] op,
         logic [ITEM_KEY_W-1:0] key, logic [LIMIT_W-1:0] limit, logic [SEL_W-1:0] sel);
      slot_reply_type reply;
      bit             placed;
      int             hits;
      reply  = '0;
      placed = 1'b0;
      hits   = 0;
      case (op)
         OP_ADD: begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (!placed && !occupied[i]) begin
                  occupied[i]     = 1'b1;
                  stored_key[i]   = key;
                  reply.slot_used = USED_W'(i);
                  placed          = 1'b1;
               end
            end
            reply.status = !placed;
         end
         OP_COUNT: begin
            for (int i = 0; i < TABLE_SLOTS; i++)
               if (occupied[i] && stored_key[i] == key) hits++;
         end
         OP_REMOVE: begin
            // Lowest-numbered matches go first, until the limit is reached.
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (hits < int'(limit) && occupied[i] && stored_key[i] == key) begin
                  occupied[i] = 1'b0;
                  hits++;
               end
            end
         end
         OP_READ: begin
            if (int'(sel) < TABLE_SLOTS && occupied[sel]) begin
               reply.entry_present = 1'b1;
               reply.entry_key     = stored_key[sel];
            end
         end
      endcase
      reply.match_total = (hits > MATCH_MAX) ? TOTAL_W'(MATCH_MAX) : TOTAL_W'(hits);
      return reply;
   endfunction

   function automatic int occupied_count();
      int n;
      n = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) n += occupied[i];
      return n;
   endfunction

   // Present one item and hold it until the block takes it.
   task automatic send_request(logic [REQ_TYPE_W-1:0] op, logic [ITEM_KEY_W-1:0] key,
         logic [LIMIT_W-1:0] limit, logic [SEL_W-1:0] sel);
      @(negedge clock);
      start            <= 1'b1;
      req_type         <= op;
      req_item_key     <= key;
      req_remove_limit <= limit;
      req_slot_select  <= sel;
      do @(posedge clock); while (busy);
      pending_replies.insert(pending_replies.size(), apply_table_request(op, key, limit, sel));
   endtask

   // Random pause between items; the idle fields carry junk the block must ignore.
   task automatic idle_between_items();
      int unsigned roll;
      int unsigned gap;
      roll = $urandom_range(99);
      if (no_idle_stretch || roll < 30) gap = 0;
      else if (roll < 60) gap = $urandom_range(4, 1);
      else if (roll < 95) gap = $urandom_range(75, 5);
      else gap = $urandom_range(200, 100);
      if (gap > 0) begin
         @(negedge clock);
         start            <= 1'b0;
         req_type         <= REQ_TYPE_W'($urandom_range(3));
         req_item_key     <= $urandom;
         req_remove_limit <= LIMIT_W'($urandom_range(127));
         req_slot_select  <= SEL_W'($urandom_range(63));
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_with_pause(logic [REQ_TYPE_W-1:0] op, logic [ITEM_KEY_W-1:0] key,
         logic [LIMIT_W-1:0] limit, logic [SEL_W-1:0] sel);
      send_request(op, key, limit, sel);
      idle_between_items();
   endtask

   function automatic logic [ITEM_KEY_W-1:0] pick_key();
      if ($urandom_range(99) < 75) return key_pool[$urandom_range(POOL_KEYS - 1)];
      return $urandom;
   endfunction

   function automatic logic [LIMIT_W-1:0] pick_limit();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 15) return '0;
      if (roll < 50) return LIMIT_W'($urandom_range(3, 1));
      if (roll < 80) return LIMIT_W'($urandom_range(64, 4));
      return LIMIT_W'($urandom_range(127, 65));
   endfunction

   function automatic logic [SEL_W-1:0] pick_slot();
      if ($urandom_range(99) < 40) return SEL_W'($urandom_range(15));
      return SEL_W'($urandom_range(TABLE_SLOTS - 1));
   endfunction

   // Filling phases favor adds; draining phases favor removes.
   function automatic logic [REQ_TYPE_W-1:0] pick_op(bit filling);
      int unsigned roll;
      roll = $urandom_range(99);
      if (filling) begin
         if (roll < 55) return OP_ADD;
         if (roll < 70) return OP_COUNT;
         if (roll < 80) return OP_REMOVE;
         return OP_READ;
      end
      if (roll < 20) return OP_ADD;
      if (roll < 40) return OP_COUNT;
      if (roll < 75) return OP_REMOVE;
      return OP_READ;
   endfunction

   // Key extremes, every request type, a zero limit, an oversized limit and hole reuse.
   task automatic test_directed_requests();
      send_with_pause(OP_READ,   32'h0,        7'd0,   6'd0);
      send_with_pause(OP_READ,   32'h0,        7'd0,   6'd63);
      send_with_pause(OP_COUNT,  32'h0,        7'd0,   6'd0);
      send_with_pause(OP_ADD,    32'h0000_0000, 7'd0,  6'd0);
      send_with_pause(OP_ADD,    32'hFFFF_FFFF, 7'd127, 6'd63);
      send_with_pause(OP_ADD,    32'hA5A5_A5A5, 7'd0,  6'd0);
      send_with_pause(OP_ADD,    32'hFFFF_FFFF, 7'd0,  6'd0);
      send_with_pause(OP_ADD,    32'h5A5A_5A5A, 7'd0,  6'd0);
      send_with_pause(OP_COUNT,  32'hFFFF_FFFF, 7'd0,  6'd0);
      send_with_pause(OP_READ,   32'h0,        7'd0,   6'd1);
      send_with_pause(OP_READ,   32'hFFFF_FFFF, 7'd0,  6'd0);
      send_with_pause(OP_REMOVE, 32'hFFFF_FFFF, 7'd0,  6'd0);
      send_with_pause(OP_REMOVE, 32'hFFFF_FFFF, 7'd1,  6'd0);
      send_with_pause(OP_READ,   32'h0,        7'd0,   6'd1);
      send_with_pause(OP_ADD,    32'h1234_5678, 7'd0,  6'd0);
      send_with_pause(OP_REMOVE, 32'hA5A5_A5A5, 7'd127, 6'd0);
      send_with_pause(OP_REMOVE, 32'hDEAD_BEEF, 7'd64, 6'd0);
      send_with_pause(OP_COUNT,  32'h0000_0000, 7'd0,  6'd0);
      send_with_pause(OP_REMOVE, 32'h0000_0000, 7'd64, 6'd0);
      send_with_pause(OP_READ,   32'h0,        7'd0,   6'd4);
      send_with_pause(OP_COUNT,  32'hFFFF_FFFF, 7'd0,  6'd0);
      send_with_pause(OP_READ,   32'h0,        7'd0,   6'd2);
   endtask

   // Fill every slot, push adds against a full table, then remove entries of each pool key.
   task automatic test_full_table();
      while (occupied_count() < TABLE_SLOTS)
         send_with_pause(OP_ADD, pick_key(), pick_limit(), pick_slot());
      repeat (3) send_with_pause(OP_ADD, pick_key(), pick_limit(), pick_slot());
      send_with_pause(OP_READ, 32'h0, 7'd0, 6'd63);
      for (int k = 0; k < POOL_KEYS; k++)
         send_with_pause(OP_COUNT, key_pool[k], pick_limit(), pick_slot());
      send_with_pause(OP_REMOVE, key_pool[1], 7'd127, pick_slot());
      send_with_pause(OP_ADD, pick_key(), pick_limit(), pick_slot());
      for (int k = 0; k < POOL_KEYS; k++)
         send_with_pause(OP_REMOVE, key_pool[k], pick_limit(), pick_slot());
   endtask

   // Mixed traffic that swings between filling and draining the table.
   task automatic test_random_mix();
      bit filling;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         filling         = ((i / 100) % 2) == 0;
         no_idle_stretch = (i % 250) < 40;
         send_with_pause(pick_op(filling), pick_key(), pick_limit(), pick_slot());
      end
      no_idle_stretch = 1'b0;
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Each reply strobe is matched against the oldest outstanding item.
   always @(posedge clock) begin : check_replies
      slot_reply_type want;
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            $error("reply strobe with no item outstanding");
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            compare_field("status",        want.status,        rsp_status);
            compare_field("slot_used",     want.slot_used,     rsp_slot_used);
            compare_field("match_total",   want.match_total,   rsp_match_total);
            compare_field("entry_present", want.entry_present, rsp_entry_present);
            compare_field("entry_key",     want.entry_key,     rsp_entry_key);
         end
      end
   end

   // Watchdog on the total run length.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: errors");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_type         = OP_ADD;
      req_item_key     = '0;
      req_remove_limit = '0;
      req_slot_select  = '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         occupied[i]   = 1'b0;
         stored_key[i] = '0;
      end
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int k = 2; k < POOL_KEYS; k++) key_pool[k] = $urandom;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_requests();
      test_full_table();
      test_random_mix();

      @(negedge clock);
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
